/* design/mbos_pkg.sv */
// ----------------------------------------------------------------------------
// mbos_pkg : shared types and constants of the masked bitfield override store
// Mode and status codes, key layout and default sizes.
// ----------------------------------------------------------------------------
package mbos_pkg;

  localparam int unsigned STORE_WORDS_DEF    = 512;
  localparam int unsigned PROTECTED_BITS_DEF = 8;

  localparam logic [31:0] ALL_ONES = 32'hffff_ffff;

  // key layout
  localparam int unsigned KEY_SIGN_BIT = 31;
  localparam int unsigned KEY_LEN_MSB  = 30;
  localparam int unsigned KEY_LEN_LSB  = 16;
  localparam int unsigned KEY_OFF_MSB  = 15;
  localparam int unsigned WORD_W       = 11;  // offset[15:5]
  localparam logic [14:0] MAX_LEN      = 15'd32;

  typedef enum logic [1:0] {
    MODE_SET   = 2'd0,
    MODE_CLEAR = 2'd1,
    MODE_GET   = 2'd2,
    MODE_MERGE = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_ABSENT    = 2'd1,
    ST_ILLEGAL   = 2'd2,
    ST_PROTECTED = 2'd3
  } status_t;

endpackage

/* design/masked_bitfield_override_store_core.sv */
// ----------------------------------------------------------------------------
// masked_bitfield_override_store_core : bitfield override store
// Two word memories (override bits, presence mask) with set / clear / get
// field and merge-word operations, one item per cycle when not stalled.
// ----------------------------------------------------------------------------
//
//  channel | ports                                               | dir
//  --------+-----------------------------------------------------+-----
//  in      | in_valid in_ready in_mode in_field_key in_field_value | in
//          | in_word_index in_base_word                          |
//  out     | out_valid out_ready out_status out_read_value       | out
//          | out_merged_word                                     |
//
//  Throughput is one item per cycle while out_ready is high and no clearing
//  pass runs: at the accept the memory read goes into stage 1, then compute
//  and write-back go into the result register, which raises out_valid.
//  A set or clear write-back is forwarded to an item whose read happens at
//  the same edge, so dependent items may follow directly.
//  After reset a clearing pass zeroes both memories, one word per cycle;
//  in_ready stays low until it ends.
//  A stalled result register holds stage 1 and then the input.
//
module masked_bitfield_override_store_core
  import mbos_pkg::*;
#(
  parameter int unsigned STORE_WORDS    = STORE_WORDS_DEF,
  parameter int unsigned PROTECTED_BITS = PROTECTED_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_mode,
  input  logic [31:0]        in_field_key,
  input  logic signed [31:0] in_field_value,
  input  logic [8:0]         in_word_index,
  input  logic [31:0]        in_base_word,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_status,
  output logic signed [31:0] out_read_value,
  output logic [31:0]        out_merged_word
);

  localparam int unsigned AW = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(STORE_WORDS - 1);

  // memories
  logic [31:0] bits_mem [STORE_WORDS];
  logic [31:0] mask_mem [STORE_WORDS];

  // clearing pass
  logic          clr_busy_r;
  logic [AW-1:0] clr_cnt_r;

  // stage 1: registered input plus read data
  logic              s1_v_r;
  mode_t             s1_mode_r;
  logic [31:0]       s1_key_r;
  logic [31:0]       s1_val_r;
  logic [31:0]       s1_base_r;
  logic [WORD_W-1:0] s1_word_r;
  logic [31:0]       s1_bits_r;
  logic [31:0]       s1_mask_r;

  // result register
  logic        out_valid_r;
  status_t     out_status_r;
  logic [31:0] out_read_value_r;
  logic [31:0] out_merged_word_r;

  logic              advance, commit, accept;
  logic [WORD_W-1:0] in_word;
  logic [AW-1:0]     rd_addr, wr_addr;
  logic              wr_item, wr_en;
  logic [31:0]       wr_bits, wr_mask;

  // stage 1 decode
  logic [14:0] len;
  logic [4:0]  bpos;
  logic [5:0]  rshift;
  logic [31:0] lowmask, fmask, fval;
  logic        legal, prot, in_range;
  logic [31:0] new_bits, new_mask;
  status_t     st_nxt;
  logic [31:0] rd_nxt, mg_nxt;

  assign advance  = !out_valid_r || out_ready;
  assign commit   = s1_v_r && advance;
  assign in_ready = !clr_busy_r && (!s1_v_r || advance);
  assign accept   = in_valid && in_ready;

  // merge addresses by word_index, the other modes by offset/32
  assign in_word = (mode_t'(in_mode) == MODE_MERGE) ?
                   {2'b00, in_word_index} : in_field_key[KEY_OFF_MSB:5];
  assign rd_addr = in_word[AW-1:0];

  always_comb begin
    len      = s1_key_r[KEY_LEN_MSB:KEY_LEN_LSB];
    bpos     = s1_key_r[4:0];
    rshift   = 6'd32 - len[5:0];
    lowmask  = ALL_ONES >> rshift;
    fmask    = lowmask << bpos;
    in_range = {1'b0, s1_word_r} < 12'(STORE_WORDS);
    legal    = (len != 15'd0) && (len <= MAX_LEN) &&
               ((7'(bpos) + 7'(len[5:0])) <= 7'd32) && in_range;
    prot     = 32'(s1_key_r[KEY_OFF_MSB:0]) < 32'(PROTECTED_BITS);

    fval = (s1_bits_r & fmask) >> bpos;
    // sign bit of the field; a full-width field gives ~lowmask == 0
    if (s1_key_r[KEY_SIGN_BIT] && fval[5'(len[5:0] - 6'd1)]) begin
      fval = fval | ~lowmask;
    end

    new_bits = s1_bits_r;
    new_mask = s1_mask_r;
    wr_item  = 1'b0;
    st_nxt   = ST_OK;
    rd_nxt   = '0;
    mg_nxt   = '0;

    case (s1_mode_r)
      MODE_MERGE: begin
        if (!in_range) begin
          st_nxt = ST_ILLEGAL;
          mg_nxt = s1_base_r;
        end else begin
          mg_nxt = (s1_base_r & ~s1_mask_r) | (s1_bits_r & s1_mask_r);
        end
      end
      MODE_GET: begin
        if (!legal) begin
          st_nxt = ST_ILLEGAL;
        end else if ((s1_mask_r & fmask) != fmask) begin
          st_nxt = ST_ABSENT;
        end else begin
          rd_nxt = fval;
        end
      end
      MODE_SET, MODE_CLEAR: begin
        if (prot) begin
          st_nxt = ST_PROTECTED;
        end else if (!legal) begin
          st_nxt = ST_ILLEGAL;
        end else begin
          wr_item = 1'b1;
          if (s1_mode_r == MODE_SET) begin
            new_bits = (s1_bits_r & ~fmask) | ((s1_val_r << bpos) & fmask);
            new_mask = s1_mask_r | fmask;
          end else begin
            new_mask = s1_mask_r & ~fmask;
          end
        end
      end
      default: begin
        st_nxt = ST_ILLEGAL;
      end
    endcase
  end

  // single write port, shared by the clearing pass and item write-back
  always_comb begin
    if (clr_busy_r) begin
      wr_en   = 1'b1;
      wr_addr = clr_cnt_r;
      wr_bits = '0;
      wr_mask = '0;
    end else begin
      wr_en   = commit && wr_item;
      wr_addr = s1_word_r[AW-1:0];
      wr_bits = new_bits;
      wr_mask = new_mask;
    end
  end

  // memories: write, plus read with write-back forwarding
  always_ff @(posedge clk) begin
    if (wr_en) begin
      bits_mem[wr_addr] <= wr_bits;
      mask_mem[wr_addr] <= wr_mask;
    end
    if (accept) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        s1_bits_r <= wr_bits;
        s1_mask_r <= wr_mask;
      end else begin
        s1_bits_r <= bits_mem[rd_addr];
        s1_mask_r <= mask_mem[rd_addr];
      end
    end
  end

  // clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clr_busy_r) begin
      if (clr_cnt_r == LAST_ADDR) begin
        clr_busy_r <= 1'b0;
      end
      clr_cnt_r <= clr_cnt_r + AW'(1);
    end
  end

  // stage 1 control and payload
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (accept) begin
      s1_v_r <= 1'b1;
    end else if (commit) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_mode_r <= mode_t'(in_mode);
      s1_key_r  <= in_field_key;
      s1_val_r  <= $unsigned(in_field_value);
      s1_base_r <= in_base_word;
      s1_word_r <= in_word;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_status_r      <= st_nxt;
      out_read_value_r  <= rd_nxt;
      out_merged_word_r <= mg_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_read_value  = $signed(out_read_value_r);
  assign out_merged_word = out_merged_word_r;

  // assertions
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !in_ready)
    else $error("item accepted during clearing pass");

  a_write_on_commit: assert property (@(posedge clk) disable iff (!rst_n)
    (!clr_busy_r && wr_en) |-> (s1_v_r && advance))
    else $error("store written without a committing item");

  a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> out_valid_r)
    else $error("committed item not presented");

  a_illegal_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_OK) |-> (out_read_value_r == '0))
    else $error("read value not zero on failed status");

endmodule
